FILE: rtl/lcwf_pkg.sv
// shared types, constants and sequencer microcode for the load cell weight filter
package lcwf_pkg;

    localparam int CODE_W    = 24;
    localparam int WEIGHT_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 33;
    localparam int DIV_W     = 32;
    localparam int DEN_W     = 24;
    localparam int CNT_W     = 6;
    localparam int PC_W      = 5;

    localparam int WEIGHT_SCALE = 100;
    localparam int DEAD_ZONE    = 200;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TIMED_OUT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SCALE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;

    typedef struct packed {
        logic               load;
        logic               step;
        logic [DIV_W-1:0]   num_mag;
        logic [DEN_W-1:0]   den_mag;
        logic               neg;
        logic [CNT_W-1:0]   iters;
    } div_ctrl_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_WAIT,
        OP_READ,
        OP_SUB_OLD,
        OP_ADD_NEW,
        OP_AVG_LO,
        OP_AVG_HI,
        OP_AVG_FIX,
        OP_DIV_STEP,
        OP_FIX,
        OP_SUB_OFF,
        OP_MUL,
        OP_DIV_SCALE,
        OP_RES_OK,
        OP_RES_TOUT,
        OP_RES_ZERO,
        OP_FILL_INIT,
        OP_FILL,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_CMD,
        C_TOUT,
        C_SCALE_ZERO,
        C_DIV_MORE,
        C_FILL_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] S_WAIT      = 5'd0;
    localparam logic [PC_W-1:0] S_DIV2      = 5'd13;
    localparam logic [PC_W-1:0] S_RES_TOUT  = 5'd16;
    localparam logic [PC_W-1:0] S_RES_ZERO  = 5'd17;
    localparam logic [PC_W-1:0] S_FILL_INIT = 5'd18;
    localparam logic [PC_W-1:0] S_FILL      = 5'd19;
    localparam logic [PC_W-1:0] S_EMIT      = 5'd21;
    localparam logic [PC_W-1:0] S_LAST      = S_EMIT;

    localparam int UCODE_DEPTH = 22;

    // jump to target when the condition holds, else fall through
    localparam uword_t UCODE [UCODE_DEPTH] = '{
        '{OP_WAIT,      C_NO_INPUT,   S_WAIT},      // 0  wait for an item
        '{OP_NOP,       C_CMD,        S_FILL_INIT}, // 1  restart
        '{OP_NOP,       C_TOUT,       S_RES_TOUT},  // 2  timed out read
        '{OP_READ,      C_NEVER,      S_WAIT},      // 3  fetch oldest entry
        '{OP_SUB_OLD,   C_NEVER,      S_WAIT},      // 4
        '{OP_ADD_NEW,   C_NEVER,      S_WAIT},      // 5  store sample
        '{OP_NOP,       C_SCALE_ZERO, S_RES_ZERO},  // 6
        '{OP_AVG_LO,    C_NEVER,      S_WAIT},      // 7  sum times reciprocal, low half
        '{OP_AVG_HI,    C_NEVER,      S_WAIT},      // 8  high half
        '{OP_AVG_FIX,   C_NEVER,      S_WAIT},      // 9  average with sign restored
        '{OP_SUB_OFF,   C_NEVER,      S_WAIT},      // 10
        '{OP_MUL,       C_NEVER,      S_WAIT},      // 11
        '{OP_DIV_SCALE, C_NEVER,      S_WAIT},      // 12 / scale
        '{OP_DIV_STEP,  C_DIV_MORE,   S_DIV2},      // 13
        '{OP_FIX,       C_NEVER,      S_WAIT},      // 14
        '{OP_RES_OK,    C_ALWAYS,     S_EMIT},      // 15
        '{OP_RES_TOUT,  C_ALWAYS,     S_EMIT},      // 16
        '{OP_RES_ZERO,  C_ALWAYS,     S_EMIT},      // 17
        '{OP_FILL_INIT, C_NEVER,      S_WAIT},      // 18
        '{OP_FILL,      C_FILL_MORE,  S_FILL},      // 19 one entry per cycle
        '{OP_NOP,       C_ALWAYS,     S_WAIT},      // 20
        '{OP_EMIT,      C_OUT_BUSY,   S_EMIT}       // 21 hand to output reg
    };

endpackage

FILE: rtl/lcwf_if.sv
// channel interfaces: input items, result items and configuration writes
interface lcwf_in_if
    import lcwf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [CODE_W-1:0] raw_code;
    logic              timed_out;

    modport source (output valid, command, raw_code, timed_out, input ready);
    modport sink (input valid, command, raw_code, timed_out, output ready);
endinterface

interface lcwf_out_if
    import lcwf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] weight_cg;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, weight_cg, status, input ready);
    modport sink (input valid, weight_cg, status, output ready);
endinterface

interface lcwf_cfg_if
    import lcwf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CODE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/lcwf_div.sv
// restoring signed divider, one quotient bit per cycle while step is set, truncates toward zero
module lcwf_div
    import lcwf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_ctrl_t               ctrl,
    output logic signed [ACC_W-1:0] quo,
    output logic                    more
);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            quo_next = ctrl.num_mag;
            rem_next = '0;
            den_next = ctrl.den_mag;
            neg_next = ctrl.neg;
            cnt_next = ctrl.iters;
        end
        else if (ctrl.step)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // true while another step follows the current one
    assign more = cnt_reg != CNT_W'(1);
    assign quo  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

FILE: rtl/load_cell_weight_filter.sv
// top level: moving average tare scale driven by a microcoded sequencer
//
//  channel  role    payload                                   transfer when
//  item     sink    command, raw_code[23:0], timed_out        item.valid & item.ready
//  result   source  weight_cg[31:0] signed, status[1:0]       result.valid & result.ready
//  cfg      sink    index[1:0] (0 scale, 1 offset), data[23:0] cfg.valid (ready always high)
//
//  one item at a time; the scale division runs in the divider, which produces
//  one quotient bit per cycle; the average is a two-step reciprocal multiply
//  a restart writes one ring entry per cycle
//  reset is immediate: per-entry valid bits make the ring read as zero, no clearing pass
//  a new item is taken while the previous result still waits in the output register;
//  only the hand-off step stalls on a busy output
module load_cell_weight_filter
    import lcwf_pkg::*;
#(
    parameter int WINDOW = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    lcwf_in_if.sink   item,
    lcwf_out_if.source result,
    lcwf_cfg_if.sink  cfg
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = CODE_W + $clog2(WINDOW);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW - 1);

    // sum / WINDOW as a multiply by a reciprocal rounded up, exact for |sum| < 2^SUM_W
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int RECIP_W = SUM_W + 1;
    localparam int LO_W    = SUM_W / 2;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int AVG_W   = PROD_W - SUM_W - LOG_W;
    localparam longint RECIP_VAL =
        ((longint'(1) <<< (SUM_W + LOG_W)) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          uword;
    logic            cond_true;

    // captured item
    logic              cmd_reg, cmd_next;
    logic              tout_reg, tout_next;
    logic [CODE_W-1:0] code_reg, code_next;

    // configuration
    logic signed [CODE_W-1:0] scale_reg, scale_next;
    logic signed [CODE_W-1:0] offset_reg, offset_next;

    // ring and running sum
    logic [CODE_W-1:0]       ring_mem [WINDOW];
    logic [WINDOW-1:0]       valid_reg, valid_next;
    logic [CODE_W-1:0]       rd_data_reg;
    logic                    rd_valid_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [CODE_W-1:0]       mem_wdata;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;

    // arithmetic
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  acc_abs;
    logic [SUM_W-1:0]         sum_abs;
    logic [DEN_W-1:0]         scale_abs;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [LO_W+RECIP_W-1:0]  part_lo;
    logic [HI_W+RECIP_W-1:0]  part_hi;
    logic [AVG_W-1:0]         avg_mag;
    div_ctrl_t                div_ctrl;
    logic signed [ACC_W-1:0]  div_quo;
    logic                     div_more;

    // result staging and output register
    logic signed [WEIGHT_W-1:0] res_weight_reg, res_weight_next;
    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [WEIGHT_W-1:0] out_weight_reg, out_weight_next;
    logic [STATUS_W-1:0]        out_status_reg, out_status_next;
    logic                       out_busy;
    logic                       emit_fire;
    logic                       in_fire;
    logic                       in_dead_zone;

    assign uword = UCODE[pc_reg];

    assign item.ready = uword.op == OP_WAIT;
    assign in_fire    = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign out_busy  = out_valid_reg && !result.ready;
    assign emit_fire = (uword.op == OP_EMIT) && !out_busy;

    assign result.valid     = out_valid_reg;
    assign result.weight_cg = out_weight_reg;
    assign result.status    = out_status_reg;

    // magnitudes for the divider
    assign sum_abs   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign acc_abs   = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign scale_abs = scale_reg[CODE_W-1] ? DEN_W'(-scale_reg) : DEN_W'(scale_reg);

    // partial products of the sum magnitude and the window reciprocal
    assign part_lo = {{RECIP_W{1'b0}}, sum_abs[LO_W-1:0]} * {{LO_W{1'b0}}, RECIP};
    assign part_hi = {{RECIP_W{1'b0}}, sum_abs[SUM_W-1:LO_W]} * {{HI_W{1'b0}}, RECIP};
    assign avg_mag = prod_reg[PROD_W-1:SUM_W+LOG_W];

    assign in_dead_zone = (acc_reg < ACC_W'(DEAD_ZONE)) && (acc_reg > ACC_W'(-DEAD_ZONE));

    // sequencer condition and next step
    always_comb
    begin
        case (uword.cond)
            C_NEVER:      cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_INPUT:   cond_true = !item.valid;
            C_CMD:        cond_true = cmd_reg;
            C_TOUT:       cond_true = tout_reg;
            C_SCALE_ZERO: cond_true = scale_reg == '0;
            C_DIV_MORE:   cond_true = div_more;
            C_FILL_MORE:  cond_true = idx_reg != LAST_SLOT;
            C_OUT_BUSY:   cond_true = out_busy;
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_true)
        begin
            pc_next = uword.target;
        end
        else if (pc_reg == S_LAST)
        begin
            pc_next = S_WAIT;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    // datapath controlled by the current control word
    always_comb
    begin
        cmd_next        = cmd_reg;
        tout_next       = tout_reg;
        code_next       = code_reg;
        valid_next      = valid_reg;
        sum_next        = sum_reg;
        slot_next       = slot_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        res_weight_next = res_weight_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = code_reg;
        div_ctrl        = '0;

        case (uword.op)
            OP_WAIT:
            begin
                if (in_fire)
                begin
                    cmd_next  = item.command;
                    tout_next = item.timed_out;
                    code_next = item.raw_code;
                end
            end
            OP_SUB_OLD:
            begin
                // entries never written since reset count as zero
                if (rd_valid_reg)
                begin
                    sum_next = sum_reg - SUM_W'($signed(rd_data_reg));
                end
            end
            OP_ADD_NEW:
            begin
                sum_next              = sum_reg + SUM_W'($signed(code_reg));
                mem_we                = 1'b1;
                valid_next[slot_reg]  = 1'b1;
                slot_next             = (slot_reg == LAST_SLOT) ? '0 : slot_reg + IDX_W'(1);
            end
            OP_AVG_LO:
            begin
                prod_next = PROD_W'(part_lo);
            end
            OP_AVG_HI:
            begin
                prod_next = prod_reg + (PROD_W'(part_hi) << LO_W);
            end
            OP_AVG_FIX:
            begin
                // magnitude quotient, truncated toward zero once the sign is back
                acc_next = sum_reg[SUM_W-1] ? -ACC_W'(avg_mag) : ACC_W'(avg_mag);
            end
            OP_DIV_STEP:
            begin
                div_ctrl.step = 1'b1;
            end
            OP_FIX:
            begin
                acc_next = div_quo;
            end
            OP_SUB_OFF:
            begin
                acc_next = acc_reg - ACC_W'(offset_reg);
            end
            OP_MUL:
            begin
                acc_next = acc_reg * ACC_W'(WEIGHT_SCALE);
            end
            OP_DIV_SCALE:
            begin
                // numerator magnitude stays below 2^31, so 31 steps suffice
                div_ctrl.load    = 1'b1;
                div_ctrl.num_mag = {acc_abs[DIV_W-2:0], 1'b0};
                div_ctrl.den_mag = scale_abs;
                div_ctrl.neg     = acc_reg[ACC_W-1] ^ scale_reg[CODE_W-1];
                div_ctrl.iters   = CNT_W'(DIV_W - 1);
            end
            OP_RES_OK:
            begin
                res_weight_next = in_dead_zone ? '0 : acc_reg[WEIGHT_W-1:0];
                res_status_next = STATUS_OK;
            end
            OP_RES_TOUT:
            begin
                res_weight_next = '0;
                res_status_next = STATUS_TIMED_OUT;
            end
            OP_RES_ZERO:
            begin
                res_weight_next = '0;
                res_status_next = STATUS_ZERO_SCALE;
            end
            OP_FILL_INIT:
            begin
                sum_next = '0;
                idx_next = '0;
            end
            OP_FILL:
            begin
                // write slot is left where it was
                mem_we              = 1'b1;
                mem_waddr           = idx_reg;
                mem_wdata           = offset_reg;
                valid_next[idx_reg] = 1'b1;
                sum_next            = sum_reg + SUM_W'(offset_reg);
                idx_next            = idx_reg + IDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        scale_next  = scale_reg;
        offset_next = offset_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SCALE:  scale_next  = cfg.data;
                REG_OFFSET: offset_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // output register, reloaded only once the previous result has gone
    always_comb
    begin
        out_valid_next  = out_valid_reg && !result.ready;
        out_weight_next = out_weight_reg;
        out_status_next = out_status_reg;
        if (emit_fire)
        begin
            out_valid_next  = 1'b1;
            out_weight_next = res_weight_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_WAIT;
            valid_reg     <= '0;
            sum_reg       <= '0;
            slot_reg      <= '0;
            scale_reg     <= CODE_W'(1);
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            slot_reg      <= slot_next;
            scale_reg     <= scale_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        tout_reg       <= tout_next;
        code_reg       <= code_next;
        idx_reg        <= idx_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        res_weight_reg <= res_weight_next;
        res_status_reg <= res_status_next;
        out_weight_reg <= out_weight_next;
        out_status_reg <= out_status_next;
    end

    // ring storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uword.op == OP_READ)
        begin
            rd_data_reg  <= ring_mem[slot_reg];
            rd_valid_reg <= valid_reg[slot_reg];
        end
    end

    lcwf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .quo   (div_quo),
        .more  (div_more)
    );

endmodule
